FILE: hdl/rar_pkg.sv
// Shared constants and operation codes for the rational reduce unit.
package rar_pkg;

  localparam int OPERAND_WIDTH_DEF = 16;
  localparam int NUM_W = 33;
  localparam int DEN_W = 31;
  localparam int ACT_W = 2;

  localparam logic [ACT_W-1:0] ACT_ADD = 2'd0;
  localparam logic [ACT_W-1:0] ACT_SUB = 2'd1;
  localparam logic [ACT_W-1:0] ACT_MUL = 2'd2;
  localparam logic [ACT_W-1:0] ACT_DIV = 2'd3;

endpackage

FILE: hdl/rar_if.sv
// Valid/ready channel interfaces for operand and result words.
interface rar_in_if
  import rar_pkg::*;
#(
  parameter int OperandWidth = OPERAND_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic [ACT_W-1:0]               action;
  logic signed [OperandWidth-1:0] left_num;
  logic signed [OperandWidth-1:0] left_den;
  logic signed [OperandWidth-1:0] right_num;
  logic signed [OperandWidth-1:0] right_den;

  modport source (output valid, action, left_num, left_den, right_num, right_den,
                  input ready);
  modport sink (input valid, action, left_num, left_den, right_num, right_den,
                output ready);
endinterface

interface rar_out_if
  import rar_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic signed [NUM_W-1:0] result_num;
  logic [DEN_W-1:0]        result_den;
  logic                    fault;

  modport source (output valid, result_num, result_den, fault, input ready);
  modport sink (input valid, result_num, result_den, fault, output ready);
endinterface

FILE: hdl/rar_front.sv
// Front end: splits operands into sign and magnitude and multiplies them.
module rar_front
  import rar_pkg::*;
#(
  parameter int OperandWidth = OPERAND_WIDTH_DEF,
  localparam int MagW = 2 * OperandWidth + 1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [ACT_W-1:0]               action,
  input  logic [OperandWidth-1:0]        left_num,
  input  logic [OperandWidth-1:0]        left_den,
  input  logic [OperandWidth-1:0]        right_num,
  input  logic [OperandWidth-1:0]        right_den,
  output logic                           q_valid,
  input  logic                           q_ready,
  output logic [MagW-1:0]                q_mag,
  output logic [MagW-1:0]                q_den,
  output logic                           q_neg,
  output logic                           q_fault
);
  localparam int PW = 2 * OperandWidth;

  // Stage 1 registers: magnitudes, signs and classification.
  logic                    s1_valid;
  logic [ACT_W-1:0]        s1_act;
  logic [OperandWidth-1:0] ln, ld, rn, rd;
  logic                    s1_sg1, s1_sg2, s1_fault;
  // Stage 2 registers: products.
  logic                    s2_valid;
  logic [ACT_W-1:0]        s2_act;
  logic [PW-1:0]           pa, pb, pd;
  logic                    s2_sg1, s2_sg2, s2_fault;

  function automatic logic [OperandWidth-1:0] mag_of(input logic [OperandWidth-1:0] v);
    mag_of = v[OperandWidth-1] ? (~v + 1'b1) : v;
  endfunction

  logic adv2, adv1;
  assign adv2     = !s2_valid || q_ready;
  assign adv1     = !s1_valid || adv2;
  assign in_ready = adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (adv1) s1_valid <= in_valid;
      if (adv2) s2_valid <= s1_valid;
    end
    if (adv1 && in_valid) begin
      s1_act   <= action;
      ln       <= mag_of(left_num);
      ld       <= mag_of(left_den);
      rn       <= mag_of(right_num);
      rd       <= mag_of(right_den);
      s1_sg1   <= left_num[OperandWidth-1] ^ left_den[OperandWidth-1];
      s1_sg2   <= right_num[OperandWidth-1] ^ right_den[OperandWidth-1];
      s1_fault <= (left_den == '0) || (right_den == '0) ||
                  (action == ACT_DIV && right_num == '0);
    end
    // Three products; the operand pairs depend on the operation.
    if (adv2 && s1_valid) begin
      s2_act   <= s1_act;
      s2_sg1   <= s1_sg1;
      s2_sg2   <= s1_sg2 ^ (s1_act == ACT_SUB);
      s2_fault <= s1_fault;
      pa       <= (s1_act == ACT_MUL) ? PW'(ln) * PW'(rn) : PW'(ln) * PW'(rd);
      pb       <= PW'(rn) * PW'(ld);
      pd       <= (s1_act == ACT_DIV) ? PW'(ld) * PW'(rn) : PW'(ld) * PW'(rd);
    end
  end

  // Combine products into a signed magnitude.
  logic [MagW-1:0] sum, da, db;
  always_comb begin
    da      = {1'b0, pa};
    db      = {1'b0, pb};
    q_den   = {1'b0, pd};
    q_fault = s2_fault;
    q_valid = s2_valid;
    sum     = da + db;
    if (s2_act == ACT_MUL || s2_act == ACT_DIV) begin
      q_mag = da;
      q_neg = s2_sg1 ^ s2_sg2;
    end else if (s2_sg1 == s2_sg2) begin
      q_mag = sum;
      q_neg = s2_sg1;
    end else if (da >= db) begin
      q_mag = da - db;
      q_neg = s2_sg1;
    end else begin
      q_mag = db - da;
      q_neg = s2_sg2;
    end
  end
endmodule

FILE: hdl/rar_queue.sv
// Two-entry queue between the front end and the reduction engine.
module rar_queue #(
  parameter int Width = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [Width-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [Width-1:0] rd_data
);
  logic [Width-1:0] slot [2];
  logic             wptr, rptr;
  logic [1:0]       count;
  logic             push, pop;

  assign wr_ready = count != 2'd2;
  assign rd_valid = count != 2'd0;
  assign rd_data  = slot[rptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= !wptr;
      if (pop) rptr <= !rptr;
      count <= count + 2'(push) - 2'(pop);
    end
    if (push) slot[wptr] <= wr_data;
  end
endmodule

FILE: hdl/rar_back.sv
// Back end: Euclidean GCD by restoring remainder steps, then two exact divisions.
module rar_back
  import rar_pkg::*;
#(
  parameter int OperandWidth = OPERAND_WIDTH_DEF,
  localparam int MagW = 2 * OperandWidth + 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    q_valid,
  output logic                    q_ready,
  input  logic [MagW-1:0]         q_mag,
  input  logic [MagW-1:0]         q_den,
  input  logic                    q_neg,
  input  logic                    q_fault,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [NUM_W-1:0] result_num,
  output logic [DEN_W-1:0]        result_den,
  output logic                    fault
);
  localparam int CW = $clog2(MagW + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_GCD  = 3'd1;
  localparam logic [2:0] ST_DVN  = 3'd2;
  localparam logic [2:0] ST_DVD  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]      state;
  logic [MagW-1:0] mag, den, ga, g;
  logic [MagW-1:0] dq, dr, dd;   // shared divider: quotient/dividend, remainder, divisor
  logic [CW-1:0]   cnt;
  logic            neg, flt;

  // One restoring division step of the shared divider.
  logic [MagW:0]   trial;
  logic [MagW-1:0] r_sh;
  always_comb begin
    r_sh  = {dr[MagW-2:0], dq[MagW-1]};
    trial = {1'b0, r_sh} - {1'b0, dd};
  end

  assign q_ready = state == ST_IDLE && !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (q_valid && q_ready) begin
            mag <= q_mag;
            den <= q_den;
            neg <= q_neg;
            flt <= q_fault;
            if (q_fault || q_mag == '0) begin
              state <= ST_DONE;
            end else begin
              ga    <= q_den;
              dq    <= q_mag;
              dd    <= q_den;
              dr    <= '0;
              cnt   <= CW'(MagW);
              state <= ST_GCD;
            end
          end
        end
        // Each pass computes a mod b bit by bit, then swaps.
        ST_GCD: begin
          if (cnt != '0) begin
            dq  <= {dq[MagW-2:0], ~trial[MagW]};
            dr  <= trial[MagW] ? r_sh : trial[MagW-1:0];
            cnt <= cnt - 1'b1;
          end else if (dr == '0) begin
            g     <= ga;
            dq    <= mag;
            dd    <= ga;
            dr    <= '0;
            cnt   <= CW'(MagW);
            state <= ST_DVN;
          end else begin
            ga  <= dr;
            dq  <= ga;
            dd  <= dr;
            dr  <= '0;
            cnt <= CW'(MagW);
          end
        end
        ST_DVN: begin
          if (cnt != '0) begin
            dq  <= {dq[MagW-2:0], ~trial[MagW]};
            dr  <= trial[MagW] ? r_sh : trial[MagW-1:0];
            cnt <= cnt - 1'b1;
          end else begin
            mag   <= dq;
            dq    <= den;
            dd    <= g;
            dr    <= '0;
            cnt   <= CW'(MagW);
            state <= ST_DVD;
          end
        end
        ST_DVD: begin
          if (cnt != '0) begin
            dq  <= {dq[MagW-2:0], ~trial[MagW]};
            dr  <= trial[MagW] ? r_sh : trial[MagW-1:0];
            cnt <= cnt - 1'b1;
          end else begin
            den   <= dq;
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          // Output register; faults and zero results come out as 0/1.
          if (flt || mag == '0) begin
            result_num <= '0;
            result_den <= DEN_W'(1);
          end else begin
            result_num <= NUM_W'(neg ? (~mag + 1'b1) : mag);
            result_den <= DEN_W'(den);
          end
          fault     <= flt;
          out_valid <= 1'b1;
          state     <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule

FILE: hdl/rational_arith_reduce_unit.sv
// Top level of the rational arithmetic reduce unit.
//
// Usage: an operand word on in_ch carries an action (add, subtract, multiply,
// divide) and two signed fractions. One result word on out_ch carries the
// reduced numerator, the positive reduced denominator and a fault flag.
// A zero denominator, or division by a zero fraction, gives fault with 0/1.
// The front end takes a word per cycle, unless a full queue backs up its
// two-stage multiply pipeline, and passes it on through a two-entry queue.
// The back end reduces one word at a time through a shared bit-serial
// divider of 2*OPERAND_WIDTH+1 bits, used for every Euclid remainder step
// and both final divisions; it takes a new word only when idle with an
// empty output register.
// Reset clears all valid flags and returns the sequencer to idle.
// When the receiver stalls, the result waits in the output register and the
// queue keeps taking words until it fills.
module rational_arith_reduce_unit
  import rar_pkg::*;
#(
  parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
  input logic      clk,
  input logic      rst,
  rar_in_if.sink   in_ch,
  rar_out_if.source out_ch
);
  localparam int MagW = 2 * OPERAND_WIDTH + 1;
  localparam int QW   = 2 * MagW + 2;

  logic            f_valid, f_ready, b_valid, b_ready;
  logic [MagW-1:0] f_mag, f_den;
  logic            f_neg, f_fault;
  logic [QW-1:0]   b_data;

  rar_front #(.OperandWidth(OPERAND_WIDTH)) u_front (
    .clk, .rst,
    .in_valid (in_ch.valid), .in_ready (in_ch.ready),
    .action (in_ch.action), .left_num (in_ch.left_num), .left_den (in_ch.left_den),
    .right_num (in_ch.right_num), .right_den (in_ch.right_den),
    .q_valid (f_valid), .q_ready (f_ready),
    .q_mag (f_mag), .q_den (f_den), .q_neg (f_neg), .q_fault (f_fault)
  );

  rar_queue #(.Width(QW)) u_queue (
    .clk, .rst,
    .wr_valid (f_valid), .wr_ready (f_ready),
    .wr_data ({f_mag, f_den, f_neg, f_fault}),
    .rd_valid (b_valid), .rd_ready (b_ready), .rd_data (b_data)
  );

  rar_back #(.OperandWidth(OPERAND_WIDTH)) u_back (
    .clk, .rst,
    .q_valid (b_valid), .q_ready (b_ready),
    .q_mag (b_data[QW-1 -: MagW]), .q_den (b_data[2 +: MagW]),
    .q_neg (b_data[1]), .q_fault (b_data[0]),
    .out_valid (out_ch.valid), .out_ready (out_ch.ready),
    .result_num (out_ch.result_num), .result_den (out_ch.result_den),
    .fault (out_ch.fault)
  );
endmodule

FILE: hdl/rar_checker.sv
// Port-level checker for the rational reduce unit, bound to the top level.
module rar_checker
  import rar_pkg::*;
(
  input logic                    clk,
  input logic                    rst,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [NUM_W-1:0] result_num,
  input logic [DEN_W-1:0]        result_den,
  input logic                    fault
);
  // A result stalled by the receiver holds its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_num) && $stable(result_den))
    else $error("stalled result changed");

  // Denominators are never zero.
  a_den: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> result_den != '0)
    else $error("zero denominator");

  // A fault always reads as 0/1.
  a_fault: assert property (@(posedge clk) disable iff (rst)
    out_valid && fault |-> result_num == '0 && result_den == DEN_W'(1))
    else $error("fault result not 0/1");

  // A zero numerator always carries denominator one.
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_num == '0 |-> result_den == DEN_W'(1))
    else $error("zero not reduced");
endmodule

bind rational_arith_reduce_unit rar_checker u_rar_checker (
  .clk, .rst,
  .out_valid (out_ch.valid), .out_ready (out_ch.ready),
  .result_num (out_ch.result_num), .result_den (out_ch.result_den),
  .fault (out_ch.fault)
);

FILE: sim/testbench.sv
// Self-checking testbench for the rational arithmetic reduce unit.
module testbench;
  import rar_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W = OPERAND_WIDTH_DEF;
  localparam longint unsigned CYCLE_LIMIT = 10_000_000;

  typedef struct {
    logic [ACT_W-1:0] action;
    logic [W-1:0]     left_num;
    logic [W-1:0]     left_den;
    logic [W-1:0]     right_num;
    logic [W-1:0]     right_den;
  } operand_word_t;

  typedef struct {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic             fault;
  } fraction_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic failed = 1'b0;
  logic stimulus_done = 1'b0;
  logic in_taken = 1'b0;
  int   gap_left = 0;
  longint unsigned cycle_count = 0;

  operand_word_t pending_words[$];
  fraction_t     expected_fractions[$];

  rar_in_if  #(.OperandWidth(W)) in_ch ();
  rar_out_if out_ch ();

  rational_arith_reduce_unit #(.OPERAND_WIDTH(W)) dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Magnitude of a two's complement operand.
  function automatic longint unsigned magnitude(input logic [W-1:0] raw);
    if (raw[W-1]) begin
      return longint'(~raw + 1'b1) & ((64'd1 << W) - 1);
    end
    return longint'(raw);
  endfunction

  // Exact reduced fraction for one operand word.
  function automatic fraction_t reduce_fraction(input operand_word_t w);
    fraction_t r;
    longint unsigned ln, ld, rn, rd, a, b, mag, den, g, h, t;
    logic s1, s2, sb, neg;
    ln = magnitude(w.left_num);
    ld = magnitude(w.left_den);
    rn = magnitude(w.right_num);
    rd = magnitude(w.right_den);
    s1 = w.left_num[W-1] ^ w.left_den[W-1];
    s2 = w.right_num[W-1] ^ w.right_den[W-1];
    if (ld == 0 || rd == 0 || (w.action == ACT_DIV && rn == 0)) begin
      r.num = '0;
      r.den = DEN_W'(1);
      r.fault = 1'b1;
      return r;
    end
    case (w.action)
      ACT_ADD, ACT_SUB: begin
        a = ln * rd;
        b = rn * ld;
        sb = (w.action == ACT_SUB) ? !s2 : s2;
        if (s1 == sb) begin
          mag = a + b;
          neg = s1;
        end else if (a >= b) begin
          mag = a - b;
          neg = s1;
        end else begin
          mag = b - a;
          neg = sb;
        end
        den = ld * rd;
      end
      ACT_MUL: begin
        mag = ln * rn;
        den = ld * rd;
        neg = s1 ^ s2;
      end
      default: begin
        mag = ln * rd;
        den = ld * rn;
        neg = s1 ^ s2;
      end
    endcase
    // Euclid on the raw magnitudes.
    g = mag;
    h = den;
    while (h != 0) begin
      t = g % h;
      g = h;
      h = t;
    end
    mag = mag / g;
    den = den / g;
    if (mag == 0) neg = 1'b0;
    r.num = NUM_W'(neg ? (~mag + 1) : mag);
    r.den = DEN_W'(den);
    r.fault = 1'b0;
    return r;
  endfunction

  // Random operand value biased toward extremes and small numbers.
  function automatic logic [W-1:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return {1'b1, {(W-1){1'b0}}};
      2: return {1'b0, {(W-1){1'b1}}};
      3: return '1;
      4, 5: return W'($urandom_range(0, 24)) - W'(12);
      default: return W'($urandom);
    endcase
  endfunction

  task automatic add_word(input logic [ACT_W-1:0] act, input logic [W-1:0] a,
                          input logic [W-1:0] b, input logic [W-1:0] c,
                          input logic [W-1:0] d);
    operand_word_t w;
    w.action = act;
    w.left_num = a;
    w.left_den = b;
    w.right_num = c;
    w.right_den = d;
    pending_words.push_back(w);
  endtask

  // Gap length: mostly none or short, sometimes long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 300);
  endfunction

  // Stimulus: directed words, then random ones.
  initial begin
    logic [W-1:0] mn, mx;
    mn = {1'b1, {(W-1){1'b0}}};
    mx = {1'b0, {(W-1){1'b1}}};
    add_word(ACT_ADD, 16'd1, 16'd2, 16'd1, 16'd3);
    add_word(ACT_SUB, 16'd1, 16'd2, 16'd1, 16'd2);
    add_word(ACT_MUL, -16'sd3, 16'd4, 16'd8, -16'sd9);
    add_word(ACT_DIV, 16'd3, -16'sd4, -16'sd6, 16'd8);
    add_word(ACT_ADD, 16'd5, 16'd0, 16'd1, 16'd1);
    add_word(ACT_MUL, 16'd5, 16'd1, 16'd1, 16'd0);
    add_word(ACT_DIV, 16'd5, 16'd7, 16'd0, 16'd3);
    add_word(ACT_MUL, 16'd0, -16'sd7, 16'd2, 16'd3);
    add_word(ACT_ADD, mn, mx, mn, mx);
    add_word(ACT_SUB, mn, mx, mx, mn);
    add_word(ACT_MUL, mn, 16'd1, mn, 16'd1);
    add_word(ACT_DIV, mn, 16'd1, 16'd1, mn);
    add_word(ACT_ADD, mx, mn, mx, mn);
    add_word(ACT_DIV, mx, mn, mn, mx);
    add_word(ACT_MUL, mn, mn, mn, mn);
    add_word(ACT_SUB, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    add_word(ACT_ADD, 16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555);
    add_word(ACT_DIV, 16'd0, 16'd1, 16'd1, 16'd1);
    for (int i = 0; i < 950; i++) begin
      add_word(ACT_W'($urandom_range(0, 3)), pick_operand(), pick_operand(),
               pick_operand(), pick_operand());
    end
    stimulus_done = 1'b1;
  end

  // Reset sequence and idle input values.
  initial begin
    in_ch.valid = 1'b0;
    in_ch.action = '0;
    in_ch.left_num = '0;
    in_ch.left_den = '0;
    in_ch.right_num = '0;
    in_ch.right_den = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
  end

  // Record each accepted operand word and its expected result.
  always @(posedge clk) begin
    operand_word_t a;
    if (!rst && in_ch.valid && in_ch.ready) begin
      a.action = in_ch.action;
      a.left_num = in_ch.left_num;
      a.left_den = in_ch.left_den;
      a.right_num = in_ch.right_num;
      a.right_den = in_ch.right_den;
      expected_fractions.push_back(reduce_fraction(a));
    end
    in_taken <= !rst && in_ch.valid && in_ch.ready;
  end

  // Driver: present words at the falling edge, with random gaps.
  always @(negedge clk) begin
    operand_word_t w;
    if (rst || !stimulus_done) begin
      in_ch.valid = 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (gap_left > 0) begin
        in_ch.valid = 1'b0;
        gap_left = gap_left - 1;
      end else if (pending_words.size() > 0) begin
        w = pending_words.pop_front();
        in_ch.valid = 1'b1;
        in_ch.action = w.action;
        in_ch.left_num = w.left_num;
        in_ch.left_den = w.left_den;
        in_ch.right_num = w.right_num;
        in_ch.right_den = w.right_den;
        gap_left = pick_gap();
      end else begin
        in_ch.valid = 1'b0;
      end
    end
  end

  // Receiver back pressure, changed at the falling edge.
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        out_ch.ready = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  // Monitor: compare each accepted result word with the oldest expectation.
  always @(posedge clk) begin
    fraction_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_fractions.size() == 0) begin
        $display("%0t: unexpected result word num=%0d den=%0d fault=%0b", $time,
                 out_ch.result_num, out_ch.result_den, out_ch.fault);
        failed <= 1'b1;
      end else begin
        e = expected_fractions.pop_front();
        if (out_ch.result_num !== e.num || out_ch.result_den !== e.den ||
            out_ch.fault !== e.fault) begin
          $display("%0t: mismatch expected num=%0d den=%0d fault=%0b, got num=%0d den=%0d fault=%0b",
                   $time, $signed(e.num), e.den, e.fault, out_ch.result_num,
                   out_ch.result_den, out_ch.fault);
          failed <= 1'b1;
        end
      end
    end
  end

  // Cycle counter that ends a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("rational_arith_reduce_unit regression: fail");
      $finish;
    end
  end

  // End of run: all words sent, all results seen, then a quiet tail.
  initial begin
    wait (stimulus_done);
    wait (pending_words.size() == 0 && !in_ch.valid);
    wait (expected_fractions.size() == 0);
    repeat (400) @(posedge clk);
    if (!failed && expected_fractions.size() == 0) begin
      $display("rational_arith_reduce_unit regression: pass");
    end else begin
      $display("rational_arith_reduce_unit regression: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/rar_pkg.sv
hdl/rar_if.sv
hdl/rar_front.sv
hdl/rar_queue.sv
hdl/rar_back.sv
hdl/rational_arith_reduce_unit.sv
hdl/rar_checker.sv
sim/testbench.sv
